// ===== rtl/kphd_pkg.sv =====
// Shared constants, key code table and lane control type for the key
// tap-and-hold detector. No dependencies.
package kphd_pkg;

  localparam int NUM_KEYS     = 14;
  localparam int REPORT_SLOTS = 4;
  localparam int SLOT_FIELDS  = 4;
  localparam int USED_SLOTS   = (REPORT_SLOTS < SLOT_FIELDS) ? REPORT_SLOTS : SLOT_FIELDS;
  localparam int CODE_COUNT   = 14;
  localparam int NW           = $clog2(USED_SLOTS + 1);

  localparam logic [7:0] COUNT_MAX    = 8'hFF;
  localparam logic [7:0] THRESH_RESET = 8'd30;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  localparam logic [7:0] KEY_CODES [CODE_COUNT] = '{
    8'h52, 8'h51, 8'h50, 8'h4F, 8'h29, 8'h2C, 8'h28,
    8'h15, 8'h05, 8'h06, 8'h08, 8'h14, 8'h16, 8'h1A
  };

  typedef struct packed {
    logic update;   // item transferred this cycle
    logic clear;    // item is a clear request
  } lane_ctrl_t;

endpackage

// ===== rtl/kphd_decode.sv =====
// Keycode decoder: counts how many report slots carry each key.
// Depends on kphd_pkg.
module kphd_decode (
  input  logic [7:0]              slot_code [kphd_pkg::USED_SLOTS],
  output logic [kphd_pkg::NW-1:0] key_hits  [kphd_pkg::NUM_KEYS]
);

  always_comb begin
    for (int k = 0; k < kphd_pkg::NUM_KEYS; k++) begin
      key_hits[k] = '0;
      if (k < kphd_pkg::CODE_COUNT) begin
        for (int s = 0; s < kphd_pkg::USED_SLOTS; s++) begin
          if (slot_code[s] == kphd_pkg::KEY_CODES[k])
            key_hits[k] = key_hits[k] + kphd_pkg::NW'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/kphd_lane.sv =====
// One key lane: press count, held flag and tap latch of a single key.
// Depends on kphd_pkg.
module kphd_lane (
  input  logic                    clk,
  input  logic                    rst,
  input  kphd_pkg::lane_ctrl_t    ctrl,
  input  logic [kphd_pkg::NW-1:0] hits,
  input  logic                    clr,
  input  logic [7:0]              thresh,
  output logic                    pressed,
  output logic                    held
);

  logic [7:0] count;
  logic [7:0] count_next;
  logic       pressed_next;
  logic       held_next;
  logic [9:0] sum;

  assign sum = {2'b00, count} + 10'(hits) + 10'd1;

  always_comb begin
    count_next   = count;
    pressed_next = pressed;
    held_next    = held;
    if (ctrl.update) begin
      if (ctrl.clear) begin
        pressed_next = pressed & ~clr;
      end else if (hits == '0) begin
        // release after counting without a hold is a tap
        if (count != 8'd0 && !held)
          pressed_next = 1'b1;
        count_next = 8'd0;
        held_next  = 1'b0;
      end else begin
        count_next = (sum > {2'b00, kphd_pkg::COUNT_MAX}) ? kphd_pkg::COUNT_MAX : sum[7:0];
        if (count_next > thresh)
          held_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= 8'd0;
      pressed <= 1'b0;
      held    <= 1'b0;
    end else begin
      count   <= count_next;
      pressed <= pressed_next;
      held    <= held_next;
    end
  end

endmodule

// ===== rtl/key_press_hold_detector.sv =====
// Key tap-and-hold detector top level: decoder, key lanes, flag merge.
// Depends on kphd_pkg, kphd_decode and kphd_lane.
//
// Input channel (in_valid/in_stall) carries either a keyboard report of
// four keycodes (kind 0) or a clear-by-mask request (kind 1). Every item
// gives exactly one result on the output channel (out_valid/out_stall):
// the pressed and held flag vectors after that item's update.
// The lane flag registers are the result, and out_valid rises in the
// cycle after the transfer. The block takes one item per cycle while no
// result waits under out_stall; all fourteen key lanes update in parallel
// from one decode pass over the slots, so nothing longer than the decode
// and one 8-bit add and compare sits between registers.
// While a result waits under out_stall, in_stall is raised and the lanes
// hold, so the shown flags stay put; a new item is taken in the same cycle
// that the waiting result is transferred.
// Synchronous reset clears all counts and flags, drops out_valid and loads
// the hold threshold with 30. The threshold port is always ready; write it
// only while the block is idle.
module key_press_hold_detector (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  key0,
  input  logic [7:0]  key1,
  input  logic [7:0]  key2,
  input  logic [7:0]  key3,
  input  logic [13:0] clear_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] pressed_flags,
  output logic [13:0] held_flags,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic [7:0] thresh;
  logic       accept;
  logic       out_valid_next;

  logic [7:0] slot_fields [kphd_pkg::SLOT_FIELDS];
  logic [7:0] slot_code   [kphd_pkg::USED_SLOTS];
  logic [kphd_pkg::NW-1:0] key_hits [kphd_pkg::NUM_KEYS];
  logic [kphd_pkg::NUM_KEYS-1:0] lane_pressed;
  logic [kphd_pkg::NUM_KEYS-1:0] lane_held;
  logic [kphd_pkg::NUM_KEYS-1:0] lane_clr;
  kphd_pkg::lane_ctrl_t ctrl;

  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  assign ctrl.update = accept;
  assign ctrl.clear  = (kind == kphd_pkg::KIND_CLEAR);

  assign slot_fields[0] = key0;
  assign slot_fields[1] = key1;
  assign slot_fields[2] = key2;
  assign slot_fields[3] = key3;

  always_comb begin
    for (int s = 0; s < kphd_pkg::USED_SLOTS; s++)
      slot_code[s] = slot_fields[s];
  end

  always_comb begin
    for (int k = 0; k < kphd_pkg::NUM_KEYS; k++)
      lane_clr[k] = (k < 14) ? clear_mask[k % 14] : 1'b0;
  end

  kphd_decode u_decode (
    .slot_code (slot_code),
    .key_hits  (key_hits)
  );

  for (genvar k = 0; k < kphd_pkg::NUM_KEYS; k++) begin : g_lane
    kphd_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .hits    (key_hits[k]),
      .clr     (lane_clr[k]),
      .thresh  (thresh),
      .pressed (lane_pressed[k]),
      .held    (lane_held[k])
    );
  end

  // merge lanes into the 14-bit result vectors
  always_comb begin
    pressed_flags = '0;
    held_flags    = '0;
    for (int k = 0; k < kphd_pkg::NUM_KEYS && k < 14; k++) begin
      pressed_flags[k] = lane_pressed[k];
      held_flags[k]    = lane_held[k];
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (accept)
      out_valid_next = 1'b1;
    else if (out_valid && !out_stall)
      out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      thresh    <= kphd_pkg::THRESH_RESET;
    end else begin
      out_valid <= out_valid_next;
      if (cfg_valid && cfg_ready)
        thresh <= cfg_data;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_on_wait: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("transfer gave no result");

  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(pressed_flags) && $stable(held_flags)))
    else $error("flags moved under a stalled result");

  a_held_not_tapped: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == kphd_pkg::KIND_CLEAR) |=> $stable(held_flags))
    else $error("clear request changed held flags");
`endif

endmodule

// ===== tb/key_press_hold_detector_tb.sv =====
// Self-checking testbench for key_press_hold_detector: clocked driver and
// monitor around the block, checked against an in-line model of the key lanes.
// Depends on kphd_pkg and the key_press_hold_detector RTL.
module key_press_hold_detector_tb;

  typedef struct packed {
    logic            kind;
    logic [3:0][7:0] slots;
    logic [13:0]     mask;
    logic            drain;   // sender waits for every result before this one
  } key_item_t;

  typedef struct packed {
    logic [13:0] pressed;
    logic [13:0] held;
  } key_flags_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = kphd_pkg::KIND_REPORT;
  logic [7:0]  key0 = 8'h00;
  logic [7:0]  key1 = 8'h00;
  logic [7:0]  key2 = 8'h00;
  logic [7:0]  key3 = 8'h00;
  logic [13:0] clear_mask = 14'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [13:0] pressed_flags;
  logic [13:0] held_flags;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;

  key_press_hold_detector uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .key0          (key0),
    .key1          (key1),
    .key2          (key2),
    .key3          (key3),
    .clear_mask    (clear_mask),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pressed_flags (pressed_flags),
    .held_flags    (held_flags),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // Model state of the key lanes
  logic [7:0]  key_count [14];
  logic [13:0] tapped;
  logic [13:0] held_now;
  logic [7:0]  hold_limit;

  key_item_t  pending_items [$];
  key_flags_t expected_flags [$];
  key_item_t  active_item;
  logic [13:0] typist_down;   // keys the random typist currently holds

  int  send_gap = 0;
  int  stall_left = 0;
  bit  quiet = 1'b0;
  int  mismatch_count = 0;
  int  results_checked = 0;
  int  reports_sent = 0;
  int  clears_sent = 0;
  int  thresholds_set = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] keycode(int k);
    case (k)
      0:  return 8'h52;
      1:  return 8'h51;
      2:  return 8'h50;
      3:  return 8'h4F;
      4:  return 8'h29;
      5:  return 8'h2C;
      6:  return 8'h28;
      7:  return 8'h15;
      8:  return 8'h05;
      9:  return 8'h06;
      10: return 8'h08;
      11: return 8'h14;
      12: return 8'h16;
      13: return 8'h1A;
      default: return 8'h00;
    endcase
  endfunction

  // Advances the lane model by one item and gives the flags it shows afterwards
  function automatic key_flags_t apply_item(key_item_t it);
    int hits [14];
    int c;
    key_flags_t r;
    if (it.kind == kphd_pkg::KIND_CLEAR) begin
      tapped &= ~it.mask;
    end else begin
      for (int k = 0; k < 14; k++) hits[k] = 0;
      for (int s = 0; s < 4; s++)
        for (int k = 0; k < 14; k++)
          if (it.slots[s] == keycode(k)) hits[k]++;
      for (int k = 0; k < 14; k++) begin
        if (hits[k] == 0) begin
          // release: a tap only if it never reached hold
          if (key_count[k] != 8'd0 && !held_now[k]) tapped[k] = 1'b1;
          key_count[k] = 8'd0;
          held_now[k] = 1'b0;
        end else begin
          c = int'(key_count[k]) + hits[k] + 1;
          if (c > 255) c = 255;
          key_count[k] = 8'(c);
          if (c > int'(hold_limit)) held_now[k] = 1'b1;
        end
      end
    end
    r.pressed = tapped;
    r.held = held_now;
    return r;
  endfunction

  // Mostly keys held over runs of reports, with clears, strays and raw noise
  function automatic key_item_t typed_item(int churn);
    key_item_t it;
    int k;
    int s;
    int start;
    int pick;
    it.kind  = kphd_pkg::KIND_REPORT;
    it.slots = $urandom;
    it.mask  = 14'($urandom);
    it.drain = ($urandom_range(0, 149) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      it.kind = kphd_pkg::KIND_CLEAR;
      if (pick < 2) it.mask = 14'h3FFF;
      return it;
    end
    if (pick < 13) begin
      it.kind = 1'($urandom);
      return it;
    end
    if ($urandom_range(1, churn) == 1) begin
      k = $urandom_range(0, 13);
      if (typist_down[k] || $countones(typist_down) < 4) typist_down[k] = ~typist_down[k];
    end
    for (s = 0; s < 4; s++) begin
      case ($urandom_range(0, 7))
        0, 1, 2: it.slots[s] = 8'h00;
        3:       it.slots[s] = 8'($urandom_range(100, 255));
        4:       it.slots[s] = 8'($urandom);
        7:       it.slots[s] = keycode($urandom_range(0, 13));
        default: begin
          // repeat of a held key where there is one
          k = $urandom_range(0, 13);
          if (typist_down != 14'h0)
            while (!typist_down[k]) k = $urandom_range(0, 13);
          it.slots[s] = keycode(k);
        end
      endcase
    end
    // every held key gets a slot of its own
    start = $urandom_range(0, 13);
    s = $urandom_range(0, 3);
    for (int i = 0; i < 14; i++) begin
      k = (start + i) % 14;
      if (typist_down[k]) begin
        it.slots[s] = keycode(k);
        s = (s + 1) % 4;
      end
    end
    return it;
  endfunction

  task automatic push_report(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d);
    key_item_t it;
    it.kind  = kphd_pkg::KIND_REPORT;
    it.slots = {d, c, b, a};
    it.mask  = 14'($urandom);
    it.drain = 1'b0;
    pending_items.push_back(it);
  endtask

  task automatic push_clear(logic [13:0] m);
    key_item_t it;
    it.kind  = kphd_pkg::KIND_CLEAR;
    it.slots = $urandom;
    it.mask  = m;
    it.drain = 1'b0;
    pending_items.push_back(it);
  endtask

  task automatic queue_typing(int n, int churn);
    for (int i = 0; i < n; i++) pending_items.push_back(typed_item(churn));
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_flags.size() != 0 || out_valid)
      @(posedge clk);
  endtask

  task automatic set_threshold(logic [7:0] value);
    wait_idle();
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    hold_limit = value;
    thresholds_set++;
  endtask

  // Driver: one item on the ports at a time, held steady while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_flags.push_back(apply_item(active_item));
        if (active_item.kind == kphd_pkg::KIND_CLEAR) clears_sent++;
        else reports_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0 &&
                     !(pending_items[0].drain && expected_flags.size() != 0)) begin
          if (!quiet && $urandom_range(0, 5) == 0) begin
            send_gap <= $urandom_range(0, 9);
            in_valid <= 1'b0;
          end else begin
            active_item = pending_items.pop_front();
            in_valid   <= 1'b1;
            kind       <= active_item.kind;
            key0       <= active_item.slots[0];
            key1       <= active_item.slots[1];
            key2       <= active_item.slots[2];
            key3       <= active_item.slots[3];
            clear_mask <= active_item.mask;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls the output at random, in bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: each result transfer against the oldest expectation
  always @(posedge clk) begin : result_check
    key_flags_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_flags.size() == 0) begin
        $display("%0t: unexpected result, pressed_flags %h held_flags %h",
                 $time, pressed_flags, held_flags);
        mismatch_count++;
      end else begin
        want = expected_flags.pop_front();
        results_checked++;
        if (pressed_flags !== want.pressed) begin
          $display("%0t: pressed_flags expected %h got %h", $time, want.pressed, pressed_flags);
          mismatch_count++;
        end
        if (held_flags !== want.held) begin
          $display("%0t: held_flags expected %h got %h", $time, want.held, held_flags);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    for (int k = 0; k < 14; k++) key_count[k] = 8'd0;
    tapped = 14'h0;
    held_now = 14'h0;
    hold_limit = kphd_pkg::THRESH_RESET;
    typist_down = 14'h0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: every key tapped, unknown codes, repeats, clears, one hold
    push_report(8'h00, 8'h00, 8'h00, 8'h00);
    push_report(8'h52, 8'h51, 8'h50, 8'h4F);
    push_report(8'h29, 8'h2C, 8'h28, 8'h15);
    push_report(8'h05, 8'h06, 8'h08, 8'h14);
    push_report(8'h16, 8'h1A, 8'h16, 8'h16);
    push_report(8'hFF, 8'h64, 8'h00, 8'h63);
    push_clear(14'h2AAA);
    push_clear(14'h0000);
    push_clear(14'h3FFF);
    repeat (7) push_report(8'h1A, 8'h1A, 8'h1A, 8'h1A);
    push_report(8'h52, 8'hFF, 8'h9A, 8'h00);
    push_clear(14'h0000);
    push_report(8'h00, 8'hC8, 8'h7F, 8'h80);
    push_clear(14'h3FFF);
    queue_typing(250, 4);

    set_threshold(8'd0);
    queue_typing(150, 3);

    // long holds so that counts reach saturation
    set_threshold(8'd255);
    typist_down = 14'h0001;
    queue_typing(200, 25);

    set_threshold(8'd254);
    typist_down = 14'h2001;
    queue_typing(150, 20);

    set_threshold(8'd253);
    queue_typing(100, 15);

    set_threshold(8'd1);
    queue_typing(150, 2);

    set_threshold(8'($urandom_range(2, 40)));
    quiet = 1'b1;
    queue_typing(200, 5);

    wait_idle();
    repeat (3) @(posedge clk);
    $display("Sent %0d reports and %0d clear requests under %0d threshold writes;",
             reports_sent, clears_sent, thresholds_set);
    $display("checked %0d flag results.", results_checked);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
